// File: design/battery_bus_protection_supervisor_assert.svh
// assertion macros for the battery bus protection supervisor
// used by the port checker; no other dependencies
`ifndef BATTERY_BUS_PROTECTION_SUPERVISOR_ASSERT_SVH
`define BATTERY_BUS_PROTECTION_SUPERVISOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BBPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bbps assertion failed");

// next-cycle implication, disabled in reset
`define BBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bbps assertion failed");

`endif

// File: design/bbps_pkg.sv
// types and constants of the battery bus protection supervisor
// no dependencies
`timescale 1ns / 1ps

package bbps_pkg;

	localparam int CellMax = 6;
	localparam int CodeW   = 10;
	localparam int SumW    = 13;
	localparam int TimeW   = 32;
	localparam int HoldW   = 16;
	localparam int BusW    = 6;
	localparam int CfgW    = 16;
	localparam int AdcMax  = 1023;

	localparam logic [BusW-1:0] BusAll     = 6'h3F;
	localparam logic [BusW-1:0] BusEstop   = 6'h07;
	localparam logic [BusW-1:0] BusAux     = 6'h04;
	localparam logic [BusW-1:0] BusNetwork = 6'h08;

	localparam logic [CodeW-1:0] CellLowReset  = 10'd682;
	localparam logic [CodeW-1:0] CellCritReset = 10'd658;
	localparam logic [SumW-1:0]  PackLowReset  = 13'd4385;
	localparam logic [CodeW-1:0] PackOverReset = 10'd701;
	localparam logic [CodeW-1:0] AuxOverReset  = 10'd713;
	localparam logic [HoldW-1:0] OcHoldReset   = 16'd5;
	localparam logic [HoldW-1:0] UvHoldReset   = 16'd1000;

	typedef enum logic [2:0] {
		CmdEstop    = 3'd0,
		CmdReboot   = 3'd1,
		CmdShutdown = 3'd2,
		CmdEnable   = 3'd3,
		CmdDisable  = 3'd4,
		CmdSet      = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		RegCellLow  = 3'd0,
		RegCellCrit = 3'd1,
		RegPackLow  = 3'd2,
		RegPackOver = 3'd3,
		RegAuxOver  = 3'd4,
		RegOcHold   = 3'd5,
		RegUvHold   = 3'd6
	} reg_idx_t;

	typedef enum logic {
		ReqMeasure = 1'b0,
		ReqCommand = 1'b1
	} req_t;

	typedef struct packed {
		logic [CodeW-1:0] cell_low_code;
		logic [CodeW-1:0] cell_critical_code;
		logic [SumW-1:0]  pack_low_sum;
		logic [CodeW-1:0] pack_over_code;
		logic [CodeW-1:0] aux_over_code;
		logic [HoldW-1:0] overcurrent_hold_ms;
		logic [HoldW-1:0] undervolt_holdoff_ms;
	} cfg_t;

	typedef struct packed {
		logic             low;
		logic             crit;
		logic [CodeW-1:0] code;
	} lane_res_t;

	// everything the merge stage needs from one word
	typedef struct packed {
		req_t                            req_type;
		logic [TimeW-1:0]                time_ms;
		logic [CellMax-1:0]              low;
		logic [CellMax-1:0]              crit;
		logic [CellMax-1:0][CodeW-1:0]   codes;
		logic                            pack_ge;
		logic                            aux_ge;
		logic [2:0]                      command_code;
		logic [BusW-1:0]                 bus_mask;
	} s1_t;

	typedef struct packed {
		logic [BusW-1:0]  bus;
		logic [TimeW-1:0] last_uv;
		logic [TimeW-1:0] pack_ok;
		logic [TimeW-1:0] aux_ok;
	} state_t;

	typedef struct packed {
		logic uv_hit;
		logic pack_ok_upd;
		logic aux_ok_upd;
	} upd_t;

	typedef struct packed {
		logic [BusW-1:0]    bus_enables;
		logic [CellMax-1:0] undervolt_cells;
		logic [CellMax-1:0] critical_cells;
		logic               pack_low;
		logic               pack_overcurrent;
		logic               aux_overcurrent;
	} res_t;

	function automatic logic [CodeW-1:0] clamp_code(input logic [CodeW-1:0] raw);
		logic [11:0] wide;
		wide = {2'b00, raw};
		if (wide > 12'(AdcMax))
			return CodeW'(AdcMax);
		return raw;
	endfunction

endpackage

// File: design/bbps_lane.sv
// one cell lane: clamps the cell code and compares it with both cell limits
// depends on bbps_pkg
`timescale 1ns / 1ps

module bbps_lane import bbps_pkg::*; (
	input  logic [CodeW-1:0] cell_code,
	input  logic [CodeW-1:0] low_code,
	input  logic [CodeW-1:0] crit_code,
	output lane_res_t        res
);

	logic [CodeW-1:0] code_c;

	always_comb begin
		code_c   = clamp_code(cell_code);
		res.code = code_c;
		res.low  = (code_c < low_code);
		res.crit = (code_c < crit_code);
	end

endmodule

// File: design/bbps_merge.sv
// merge stage: picks the undervoltage cell, sums the pack, times overcurrent
// and works out the next bus state; depends on bbps_pkg
`timescale 1ns / 1ps

module bbps_merge import bbps_pkg::*; (
	input  s1_t    item,
	input  state_t st,
	input  cfg_t   cfg,
	output res_t   res,
	output upd_t   upd
);

	logic [TimeW-1:0]   uv_age;
	logic [TimeW-1:0]   pack_age;
	logic [TimeW-1:0]   aux_age;
	logic               holdoff_ok;
	logic [CellMax-1:0] low_q;
	logic [CellMax-1:0] uv_cells;
	logic [CellMax-1:0] crit_cells;
	logic [SumW-1:0]    sum;
	logic               pack_low;
	logic               pack_oc;
	logic               aux_oc;
	logic [BusW-1:0]    bus;

	always_comb begin
		uv_age     = item.time_ms - st.last_uv;
		pack_age   = item.time_ms - st.pack_ok;
		aux_age    = item.time_ms - st.aux_ok;
		holdoff_ok = (uv_age > {16'd0, cfg.undervolt_holdoff_ms});

		// only the lowest low cell can raise undervoltage
		low_q      = holdoff_ok ? item.low : '0;
		uv_cells   = low_q & (~low_q + CellMax'(1));
		crit_cells = item.crit & ~uv_cells;

		sum = '0;
		for (int i = 0; i < CellMax; i++)
			sum = sum + SumW'(item.codes[i]);
		pack_low = (sum < cfg.pack_low_sum);

		pack_oc = item.pack_ge && (pack_age >= {16'd0, cfg.overcurrent_hold_ms});
		aux_oc  = item.aux_ge && (aux_age >= {16'd0, cfg.overcurrent_hold_ms});

		bus = st.bus;
		upd = '0;
		if (item.req_type == ReqMeasure) begin
			if (uv_cells != '0)
				bus = bus & ~BusEstop;
			if ((crit_cells != '0) || pack_low)
				bus = '0;
			if (pack_oc)
				bus = bus & ~BusEstop;
			if (aux_oc)
				bus = bus & ~BusAux;
			upd.uv_hit      = (uv_cells != '0);
			upd.pack_ok_upd = !item.pack_ge;
			upd.aux_ok_upd  = !item.aux_ge;
		end else begin
			case (cmd_t'(item.command_code))
				CmdEstop:    bus = bus & ~BusEstop;
				CmdReboot:   bus = BusAll;
				CmdShutdown: bus = '0;
				CmdEnable:   bus = bus | item.bus_mask;
				CmdDisable:  bus = bus & ~(item.bus_mask & ~BusNetwork);
				CmdSet:      bus = item.bus_mask | BusNetwork;
				default:     bus = bus;
			endcase
		end

		res.bus_enables = bus;
		if (item.req_type == ReqMeasure) begin
			res.undervolt_cells  = uv_cells;
			res.critical_cells   = crit_cells;
			res.pack_low         = pack_low;
			res.pack_overcurrent = pack_oc;
			res.aux_overcurrent  = aux_oc;
		end else begin
			res.undervolt_cells  = '0;
			res.critical_cells   = '0;
			res.pack_low         = 1'b0;
			res.pack_overcurrent = 1'b0;
			res.aux_overcurrent  = 1'b0;
		end
	end

endmodule

// File: design/battery_bus_protection_supervisor.sv
// flow: an accepted word is held in the lane register, and its result word in the output register
// throughput: one word per cycle while the result words are taken, set by the lane register and the merge stage
// that updates the bus and timer state once per word
// reset: all six buses on, all time marks zero, limits at their default codes,
// no word in flight
`timescale 1ns / 1ps

module battery_bus_protection_supervisor import bbps_pkg::*; #(
	parameter int CELL_COUNT = 6
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// time_ms[31:0], cell0..cell5_code[91:32], pack_current_code[101:92],
	// aux_current_code[111:102], command_code[114:112], bus_mask[120:115]
	input  logic [127:0] s_axis_tdata,
	// req_type
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// bus_enables[5:0], undervolt_cells[11:6], critical_cells[17:12],
	// pack_low[18], pack_overcurrent[19], aux_overcurrent[20]
	output logic [23:0]  m_axis_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	cfg_t      cfg_q;
	state_t    st_q;
	s1_t       item_s1;
	logic      valid_s1;
	res_t      out_q;
	logic      out_valid_q;
	s1_t       item_c;
	lane_res_t lane [CellMax];
	res_t      res_c;
	upd_t      upd_c;
	logic      out_free;
	logic      s1_fire;
	logic      in_fire;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_low_code        <= CellLowReset;
			cfg_q.cell_critical_code   <= CellCritReset;
			cfg_q.pack_low_sum         <= PackLowReset;
			cfg_q.pack_over_code       <= PackOverReset;
			cfg_q.aux_over_code        <= AuxOverReset;
			cfg_q.overcurrent_hold_ms  <= OcHoldReset;
			cfg_q.undervolt_holdoff_ms <= UvHoldReset;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				RegCellLow:  cfg_q.cell_low_code        <= cfg_data[CodeW-1:0];
				RegCellCrit: cfg_q.cell_critical_code   <= cfg_data[CodeW-1:0];
				RegPackLow:  cfg_q.pack_low_sum         <= cfg_data[SumW-1:0];
				RegPackOver: cfg_q.pack_over_code       <= cfg_data[CodeW-1:0];
				RegAuxOver:  cfg_q.aux_over_code        <= cfg_data[CodeW-1:0];
				RegOcHold:   cfg_q.overcurrent_hold_ms  <= cfg_data;
				RegUvHold:   cfg_q.undervolt_holdoff_ms <= cfg_data;
				default:     ;
			endcase
		end
	end

	// cell lanes; cells past CELL_COUNT count as zero and raise nothing
	for (genvar g = 0; g < CellMax; g++) begin : g_lane
		if (g < CELL_COUNT) begin : g_on
			bbps_lane u_lane (
				.cell_code(s_axis_tdata[32 + g*CodeW +: CodeW]),
				.low_code (cfg_q.cell_low_code),
				.crit_code(cfg_q.cell_critical_code),
				.res      (lane[g])
			);
		end else begin : g_off
			assign lane[g] = '0;
		end
	end

	always_comb begin
		item_c.req_type     = req_t'(s_axis_tuser);
		item_c.time_ms      = s_axis_tdata[31:0];
		for (int i = 0; i < CellMax; i++) begin
			item_c.low[i]   = lane[i].low;
			item_c.crit[i]  = lane[i].crit;
			item_c.codes[i] = lane[i].code;
		end
		item_c.pack_ge      = clamp_code(s_axis_tdata[101:92]) >= cfg_q.pack_over_code;
		item_c.aux_ge       = clamp_code(s_axis_tdata[111:102]) >= cfg_q.aux_over_code;
		item_c.command_code = s_axis_tdata[114:112];
		item_c.bus_mask     = s_axis_tdata[120:115];
	end

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s1_fire       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			item_s1 <= item_c;
	end

	bbps_merge u_merge (
		.item(item_s1),
		.st  (st_q),
		.cfg (cfg_q),
		.res (res_c),
		.upd (upd_c)
	);

	// bus and timer state move once per word leaving the lane register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.bus     <= BusAll;
			st_q.last_uv <= '0;
			st_q.pack_ok <= '0;
			st_q.aux_ok  <= '0;
		end else if (s1_fire) begin
			st_q.bus <= res_c.bus_enables;
			if (upd_c.uv_hit)
				st_q.last_uv <= item_s1.time_ms;
			if (upd_c.pack_ok_upd)
				st_q.pack_ok <= item_s1.time_ms;
			if (upd_c.aux_ok_upd)
				st_q.aux_ok <= item_s1.time_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (s1_fire)
			out_q <= res_c;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_q.aux_overcurrent, out_q.pack_overcurrent,
		out_q.pack_low, out_q.critical_cells, out_q.undervolt_cells, out_q.bus_enables};

endmodule

// File: design/bbps_checker.sv
// port checker for the battery bus protection supervisor, bound to the top level
// depends on battery_bus_protection_supervisor_assert.svh
`timescale 1ns / 1ps
`include "battery_bus_protection_supervisor_assert.svh"

module bbps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	logic out_word;

	assign out_word = m_axis_tvalid && m_axis_tready;

	`BBPS_ASSERT_NEXT(a_hold_valid, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	// at most one cell raises undervoltage per word
	`BBPS_ASSERT_NOW(a_uv_onehot, clk, arst_n, out_word, $onehot0(m_axis_tdata[11:6]))
	// a cell never reports undervoltage and critical at once
	`BBPS_ASSERT_NOW(a_uv_crit, clk, arst_n, out_word, (m_axis_tdata[11:6] & m_axis_tdata[17:12]) == 6'd0)
	// critical cell or low pack leaves every bus off
	`BBPS_ASSERT_NOW(a_all_off, clk, arst_n, out_word && (m_axis_tdata[18] || m_axis_tdata[17:12] != 6'd0), m_axis_tdata[5:0] == 6'd0)
	// pack overcurrent leaves motor, low current and aux off
	`BBPS_ASSERT_NOW(a_oc_off, clk, arst_n, out_word && m_axis_tdata[19], m_axis_tdata[2:0] == 3'd0)

endmodule

bind battery_bus_protection_supervisor bbps_checker u_bbps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

// File: tb/sv/battery_bus_protection_supervisor_tb.sv
// testbench for the battery bus protection supervisor: random and directed words
// checked against a behavioral model of the bus and timer state
// depends on bbps_pkg and battery_bus_protection_supervisor
`timescale 1ns / 1ps

module battery_bus_protection_supervisor_tb;
	import bbps_pkg::*;

	localparam int CycleLimit = 400000;
	localparam logic [2:0] RegSpare   = 3'd7;
	localparam logic [2:0] CmdSpareLo = 3'd6;
	localparam logic [2:0] CmdSpareHi = 3'd7;

	typedef enum {LimDefault, LimNear, LimMax, LimZero, LimRaw} limit_set_t;

	typedef struct {
		req_t                          kind;
		logic [TimeW-1:0]              t;
		logic [CellMax-1:0][CodeW-1:0] cells;
		logic [CodeW-1:0]              pack_cur;
		logic [CodeW-1:0]              aux_cur;
		logic [2:0]                    cmd;
		logic [BusW-1:0]               mask;
	} supv_word_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [23:0]  m_axis_tdata;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [15:0]  cfg_data = '0;

	// model of the block
	cfg_t             limits;
	logic [BusW-1:0]  bus_now;
	logic [TimeW-1:0] last_uv_ms, pack_ok_ms, aux_ok_ms;

	supv_word_t pending_words[$];
	res_t       expected_results[$];
	supv_word_t held_word;
	bit         word_held = 1'b0;
	int         send_idle_pct = 0, recv_idle_pct = 0;
	int         fail_count = 0;
	int         cycle_count = 0;
	logic [TimeW-1:0] now_ms = '0;
	bit         pack_hot = 1'b0, aux_hot = 1'b0;

	battery_bus_protection_supervisor dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		limits = '{cell_low_code: CellLowReset, cell_critical_code: CellCritReset,
			pack_low_sum: PackLowReset, pack_over_code: PackOverReset,
			aux_over_code: AuxOverReset, overcurrent_hold_ms: OcHoldReset,
			undervolt_holdoff_ms: UvHoldReset};
		bus_now = BusAll;
		last_uv_ms = '0;
		pack_ok_ms = '0;
		aux_ok_ms = '0;
	end

	function automatic res_t supervise(input supv_word_t w);
		res_t             r;
		logic [SumW-1:0]  sum;
		logic [TimeW-1:0] dt;
		int               i;
		r = '0;
		if (w.kind == ReqMeasure) begin
			sum = '0;
			for (i = 0; i < CellMax; i++) begin
				sum += SumW'(w.cells[i]);
				dt = w.t - last_uv_ms;
				if (w.cells[i] < limits.cell_low_code &&
						dt > TimeW'(limits.undervolt_holdoff_ms)) begin
					// one undervolt per holdoff window, later cells fall to the critical test
					r.undervolt_cells[i] = 1'b1;
					bus_now &= ~BusEstop;
					last_uv_ms = w.t;
				end else if (w.cells[i] < limits.cell_critical_code) begin
					r.critical_cells[i] = 1'b1;
					bus_now = '0;
				end
			end
			if (sum < limits.pack_low_sum) begin
				r.pack_low = 1'b1;
				bus_now = '0;
			end
			if (w.pack_cur >= limits.pack_over_code) begin
				if (w.t - pack_ok_ms >= TimeW'(limits.overcurrent_hold_ms)) begin
					r.pack_overcurrent = 1'b1;
					bus_now &= ~BusEstop;
				end
			end else begin
				pack_ok_ms = w.t;
			end
			if (w.aux_cur >= limits.aux_over_code) begin
				if (w.t - aux_ok_ms >= TimeW'(limits.overcurrent_hold_ms)) begin
					r.aux_overcurrent = 1'b1;
					bus_now &= ~BusAux;
				end
			end else begin
				aux_ok_ms = w.t;
			end
		end else begin
			case (w.cmd)
				CmdEstop:    bus_now &= ~BusEstop;
				CmdReboot:   bus_now = BusAll;
				CmdShutdown: bus_now = '0;
				CmdEnable:   bus_now |= w.mask;
				// network stays on through a disable
				CmdDisable:  bus_now &= ~(w.mask & ~BusNetwork);
				CmdSet:      bus_now = w.mask | BusNetwork;
				default: ;
			endcase
		end
		r.bus_enables = bus_now;
		return r;
	endfunction

	task automatic push_meas(input logic [TimeW-1:0] t, input logic [CellMax-1:0][CodeW-1:0] cells,
			input logic [CodeW-1:0] pc, input logic [CodeW-1:0] ac);
		supv_word_t w;
		w.kind = ReqMeasure;
		w.t = t;
		w.cells = cells;
		w.pack_cur = pc;
		w.aux_cur = ac;
		w.cmd = 3'($urandom_range(7));
		w.mask = BusW'($urandom_range(63));
		pending_words.push_back(w);
	endtask

	task automatic push_cmd(input logic [2:0] code, input logic [BusW-1:0] mask);
		supv_word_t w;
		int         i;
		w.kind = ReqCommand;
		w.t = $urandom();
		for (i = 0; i < CellMax; i++)
			w.cells[i] = CodeW'($urandom_range(1023));
		w.pack_cur = CodeW'($urandom_range(1023));
		w.aux_cur = CodeW'($urandom_range(1023));
		w.cmd = code;
		w.mask = mask;
		pending_words.push_back(w);
	endtask

	function automatic logic [CodeW-1:0] near_code(input logic [CodeW-1:0] thr);
		int v;
		v = int'(thr) + int'($urandom_range(6)) - 3;
		if (v < 0)
			v = 0;
		if (v > AdcMax)
			v = AdcMax;
		return CodeW'(v);
	endfunction

	function automatic logic [CodeW-1:0] pick_cell();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return CodeW'($urandom_range(1023));
		if (r < 25)
			return near_code(limits.cell_low_code);
		if (r < 35)
			return near_code(limits.cell_critical_code);
		if (r < 40)
			return ($urandom_range(1) != 0) ? CodeW'(AdcMax) : '0;
		return CodeW'($urandom_range(1023, limits.cell_low_code));
	endfunction

	function automatic logic [CodeW-1:0] pick_current(input logic [CodeW-1:0] thr, input bit hot);
		if ($urandom_range(9) == 0)
			return CodeW'($urandom_range(1023));
		if (hot)
			return CodeW'($urandom_range(1023, thr));
		if (thr == '0)
			return '0;
		return CodeW'($urandom_range(thr - 1, 0));
	endfunction

	// mostly small time steps so overcurrent runs last long enough to trip
	task automatic push_random_word();
		logic [CellMax-1:0][CodeW-1:0] cv;
		int                            r, i;
		r = $urandom_range(99);
		if (r < 3)
			now_ms = $urandom();
		else if (r < 13)
			now_ms += $urandom_range(1500, 200);
		else
			now_ms += $urandom_range(8);
		if ($urandom_range(99) < 20)
			pack_hot = !pack_hot;
		if ($urandom_range(99) < 20)
			aux_hot = !aux_hot;
		if ($urandom_range(99) < 30) begin
			if ($urandom_range(99) < 30)
				push_cmd(CmdReboot, BusW'($urandom_range(63)));
			else
				push_cmd(3'($urandom_range(7)), BusW'($urandom_range(63)));
		end else begin
			for (i = 0; i < CellMax; i++)
				cv[i] = pick_cell();
			push_meas(now_ms, cv, pick_current(limits.pack_over_code, pack_hot),
				pick_current(limits.aux_over_code, aux_hot));
		end
	endtask

	task automatic write_limit(input logic [2:0] idx, input logic [15:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			RegCellLow:  limits.cell_low_code = data[CodeW-1:0];
			RegCellCrit: limits.cell_critical_code = data[CodeW-1:0];
			RegPackLow:  limits.pack_low_sum = data[SumW-1:0];
			RegPackOver: limits.pack_over_code = data[CodeW-1:0];
			RegAuxOver:  limits.aux_over_code = data[CodeW-1:0];
			RegOcHold:   limits.overcurrent_hold_ms = data[HoldW-1:0];
			RegUvHold:   limits.undervolt_holdoff_ms = data[HoldW-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_limits(input limit_set_t kind);
		logic [15:0] raw [8];
		logic [15:0] low_v;
		case (kind)
			LimDefault: begin
				raw[RegCellLow] = 16'(CellLowReset);
				raw[RegCellCrit] = 16'(CellCritReset);
				raw[RegPackLow] = 16'(PackLowReset);
				raw[RegPackOver] = 16'(PackOverReset);
				raw[RegAuxOver] = 16'(AuxOverReset);
				raw[RegOcHold] = OcHoldReset;
				raw[RegUvHold] = UvHoldReset;
			end
			LimNear: begin
				low_v = 16'($urandom_range(760, 600));
				raw[RegCellLow] = low_v;
				raw[RegCellCrit] = low_v - 16'($urandom_range(60));
				raw[RegPackLow] = 16'($urandom_range(5000, 3800));
				raw[RegPackOver] = 16'($urandom_range(900, 500));
				raw[RegAuxOver] = 16'($urandom_range(900, 500));
				raw[RegOcHold] = 16'($urandom_range(20));
				raw[RegUvHold] = 16'($urandom_range(1500));
			end
			LimMax:  foreach (raw[i]) raw[i] = 16'hFFFF;
			LimZero: foreach (raw[i]) raw[i] = 16'h0000;
			default: foreach (raw[i]) raw[i] = 16'($urandom_range(65535));
		endcase
		write_limit(RegCellLow, raw[RegCellLow]);
		write_limit(RegCellCrit, raw[RegCellCrit]);
		write_limit(RegPackLow, raw[RegPackLow]);
		write_limit(RegPackOver, raw[RegPackOver]);
		write_limit(RegAuxOver, raw[RegAuxOver]);
		write_limit(RegOcHold, raw[RegOcHold]);
		write_limit(RegUvHold, raw[RegUvHold]);
		// out of range index must leave every limit alone
		if (kind == LimRaw)
			write_limit(RegSpare, raw[RegSpare]);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || word_held || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [5:0] exp_v, input logic [5:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %h, got %h", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	// driver: holds a word until it is taken, then predicts its result
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			word_held = 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(supervise(held_word));
				word_held = 1'b0;
			end
			if (!word_held) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					held_word = pending_words.pop_front();
					word_held = 1'b1;
					s_axis_tdata <= {7'd0, held_word.mask, held_word.cmd, held_word.aux_cur,
						held_word.pack_cur, held_word.cells, held_word.t};
					s_axis_tuser <= held_word.kind;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		res_t exp_r;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$error("result word %h with nothing expected", m_axis_tdata);
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					check_field("bus_enables", exp_r.bus_enables, m_axis_tdata[5:0]);
					check_field("undervolt_cells", exp_r.undervolt_cells, m_axis_tdata[11:6]);
					check_field("critical_cells", exp_r.critical_cells, m_axis_tdata[17:12]);
					check_field("pack_low", 6'(exp_r.pack_low), 6'(m_axis_tdata[18]));
					check_field("pack_overcurrent", 6'(exp_r.pack_overcurrent),
						6'(m_axis_tdata[19]));
					check_field("aux_overcurrent", 6'(exp_r.aux_overcurrent),
						6'(m_axis_tdata[20]));
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		logic [CellMax-1:0][CodeW-1:0] cv;
		int                            mode;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 18;
		recv_idle_pct = 77;

		// directed words on the reset limits
		push_meas(32'd0, {6{10'd800}}, 10'd0, 10'd0);
		// first low cell raises undervolt, the next one only counts as critical
		cv = {6{10'd800}};
		cv[2] = 10'd600;
		cv[4] = 10'd600;
		push_meas(32'd1001, cv, 10'd0, 10'd0);
		push_cmd(CmdReboot, 6'h00);
		cv = {6{10'd1023}};
		cv[0] = 10'd670;
		push_meas(32'd1500, cv, 10'd0, 10'd0);
		// holdoff exactly elapsed is not enough
		cv[0] = 10'd0;
		push_meas(32'd2001, cv, 10'd0, 10'd0);
		push_cmd(CmdReboot, 6'h00);
		cv = {6{10'd1023}};
		cv[1] = 10'd0;
		push_meas(32'd2002, cv, 10'd0, 10'd0);
		push_meas(32'd3000, {6{10'd700}}, 10'd0, 10'd0);
		push_cmd(CmdReboot, 6'h00);
		// overcurrent has to last the hold time
		push_meas(32'd4000, {6{10'd1023}}, 10'd0, 10'd0);
		push_meas(32'd4004, {6{10'd1023}}, 10'd701, 10'd0);
		push_meas(32'd4005, {6{10'd1023}}, 10'd1023, 10'd0);
		push_meas(32'd4006, {6{10'd1023}}, 10'd1023, 10'd713);
		push_meas(32'd4010, {6{10'd1023}}, 10'd700, 10'd1023);
		push_cmd(CmdReboot, 6'h00);
		push_cmd(CmdEstop, 6'h3F);
		push_cmd(CmdEnable, 6'h07);
		push_cmd(CmdDisable, 6'h3F);
		push_cmd(CmdSet, 6'h00);
		push_cmd(CmdSet, 6'h37);
		push_cmd(CmdShutdown, 6'h3F);
		push_cmd(CmdSpareLo, 6'h3F);
		push_cmd(CmdSpareHi, 6'h3F);
		push_cmd(CmdEnable, 6'h3F);
		// time wraps through zero
		push_meas(32'hFFFF_FFFF, {6{10'd1023}}, 10'd0, 10'd0);
		push_meas(32'd4, {6{10'd1023}}, 10'd1023, 10'd1023);
		now_ms = 32'd4;
		wait_drained();

		for (mode = 0; mode < 3; mode++) begin
			if (mode == 0) begin
				send_idle_pct = 18;
				recv_idle_pct = 77;
			end else if (mode == 1) begin
				send_idle_pct = 77;
				recv_idle_pct = 18;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			apply_limits(LimDefault);
			repeat (160) push_random_word();
			wait_drained();
			apply_limits(LimNear);
			repeat (160) push_random_word();
			wait_drained();
			apply_limits(mode == 0 ? LimMax : (mode == 1 ? LimZero : LimRaw));
			repeat (110) push_random_word();
			wait_drained();
		end

		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/bbps_pkg.sv
design/bbps_lane.sv
design/bbps_merge.sv
design/battery_bus_protection_supervisor.sv
design/bbps_checker.sv
tb/sv/battery_bus_protection_supervisor_tb.sv
